// ===== rtl/core/wtr_pkg.sv =====
package wtr_pkg;

    localparam int MAX_RESULTS  = 6;
    localparam int CHAR_W       = 8;
    localparam int CNT_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_CHAR  = 2'd1,
        OP_END   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_MODE = 2'd0,
        REG_IGNORE_CASE  = 2'd1
    } t_reg;

    typedef enum logic [1:0] {
        MODE_SQL  = 2'd0,
        MODE_GLOB = 2'd1,
        MODE_PASS = 2'd2
    } t_mode;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QUEST   = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_BSL     = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][CHAR_W-1:0] bytes;
        logic [CNT_W-1:0]                   count;
    } t_cmd;

endpackage

// ===== rtl/core/wtr_front.sv =====
module wtr_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_opcode,
    input  logic [wtr_pkg::CHAR_W-1:0]           i_char_code,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wtr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wtr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_full,
    output logic                                 o_push,
    output wtr_pkg::t_cmd                        o_cmd
);

    logic [1:0]                   r_mode;
    logic                         r_icase;
    logic                         r_esc;
    logic                         n_esc;
    logic                         accept;
    logic                         pass;
    logic [wtr_pkg::CHAR_W-1:0]   c;
    logic [wtr_pkg::CHAR_W-1:0]   multi;
    logic [wtr_pkg::CHAR_W-1:0]   single;
    logic                         is_up;
    logic                         is_low;
    logic [wtr_pkg::CHAR_W-1:0]   up;
    logic [3:0][wtr_pkg::CHAR_W-1:0] lit;
    logic [2:0]                   lit_len;
    logic [2:0]                   pre;
    wtr_pkg::t_cmd                cmd;

    assign o_ready     = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign c           = i_char_code;
    assign pass        = r_mode[1];
    assign multi       = (r_mode == wtr_pkg::MODE_GLOB) ? wtr_pkg::CH_STAR : wtr_pkg::CH_PERCENT;
    assign single      = (r_mode == wtr_pkg::MODE_GLOB) ? wtr_pkg::CH_QUEST : wtr_pkg::CH_UNDER;
    assign is_up       = (c >= 8'h41) && (c <= 8'h5A);
    assign is_low      = (c >= 8'h61) && (c <= 8'h7A);
    assign up          = is_low ? c - wtr_pkg::CASE_DIFF : c;

    // literal form of the byte
    always_comb begin
        lit = '0;
        if (r_icase && (is_up || is_low)) begin
            lit[0]  = wtr_pkg::CH_LBRACK;
            lit[1]  = up;
            lit[2]  = up + wtr_pkg::CASE_DIFF;
            lit[3]  = wtr_pkg::CH_RBRACK;
            lit_len = 3'd4;
        end else if (c == wtr_pkg::CH_STAR || c == wtr_pkg::CH_DOT || c == wtr_pkg::CH_BSL) begin
            lit[0]  = wtr_pkg::CH_BSL;
            lit[1]  = c;
            lit_len = 3'd2;
        end else begin
            lit[0]  = c;
            lit_len = 3'd1;
        end
    end

    always_comb begin
        cmd   = '0;
        n_esc = r_esc;
        pre   = 3'd0;
        unique case (i_opcode)
            wtr_pkg::OP_START: begin
                n_esc = 1'b0;
                if (!pass) begin
                    cmd.bytes[0] = wtr_pkg::CH_CARET;
                    cmd.count    = 3'd1;
                end
            end
            wtr_pkg::OP_END: begin
                n_esc = 1'b0;
                if (!pass) begin
                    cmd.bytes[0] = wtr_pkg::CH_DOLLAR;
                    cmd.bytes[1] = wtr_pkg::CH_NUL;
                    cmd.count    = 3'd2;
                end else begin
                    cmd.bytes[0] = wtr_pkg::CH_NUL;
                    cmd.count    = 3'd1;
                end
            end
            wtr_pkg::OP_CHAR: begin
                if (c != wtr_pkg::CH_NUL) begin
                    if (pass) begin
                        cmd.bytes[0] = c;
                        cmd.count    = 3'd1;
                    end else if (r_esc || (c != wtr_pkg::CH_BSL && c != multi && c != single)) begin
                        n_esc = 1'b0;
                        if (r_esc && c != multi && c != single) begin
                            pre = 3'd2;
                        end
                        for (int i = 0; i < wtr_pkg::MAX_RESULTS; i++) begin
                            if (3'(i) < pre) begin
                                cmd.bytes[i] = wtr_pkg::CH_BSL;
                            end else if (3'(i) - pre < lit_len) begin
                                cmd.bytes[i] = lit[2'(3'(i) - pre)];
                            end
                        end
                        cmd.count = pre + lit_len;
                    end else if (c == wtr_pkg::CH_BSL) begin
                        n_esc = 1'b1;
                    end else if (c == multi) begin
                        cmd.bytes[0] = wtr_pkg::CH_DOT;
                        cmd.bytes[1] = wtr_pkg::CH_STAR;
                        cmd.count    = 3'd2;
                    end else begin
                        cmd.bytes[0] = wtr_pkg::CH_DOT;
                        cmd.count    = 3'd1;
                    end
                end
            end
            default: begin
                cmd   = '0;
                n_esc = r_esc;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 2'd0;
            r_icase <= 1'b0;
            r_esc   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == wtr_pkg::REG_PATTERN_MODE) begin
                    r_mode <= i_cfg_data[1:0];
                end else if (i_cfg_index == wtr_pkg::REG_IGNORE_CASE) begin
                    r_icase <= i_cfg_data[0];
                end
            end
            if (accept) begin
                r_esc <= n_esc;
            end
        end
    end

    a_esc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_opcode == wtr_pkg::OP_START || i_opcode == wtr_pkg::OP_END) |=> !r_esc)
        else $error("escape flag survived start or end");

    a_esc_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !(n_esc && !r_esc))
        else $error("escape set by an item that produced output");

endmodule

// ===== rtl/core/wtr_queue.sv =====
module wtr_queue #(
    parameter int DEPTH = wtr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wtr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output wtr_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wtr_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];
    assign n_wptr  = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr  = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/wtr_back.sv =====
module wtr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  wtr_pkg::t_cmd                i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [wtr_pkg::CHAR_W-1:0]   o_out_char,
    output logic                         o_run_last
);

    wtr_pkg::t_cmd             r_cmd;
    wtr_pkg::t_cmd             n_cmd;
    logic [wtr_pkg::CNT_W-1:0] r_idx;
    logic [wtr_pkg::CNT_W-1:0] n_idx;
    logic                      r_busy;
    logic                      n_busy;
    logic                      last;
    logic                      xfer;

    assign last       = (r_idx == r_cmd.count - 1'b1);
    assign xfer       = r_busy && i_ready;
    assign o_valid    = r_busy;
    assign o_out_char = r_cmd.bytes[r_idx];
    assign o_run_last = last;

    always_comb begin
        n_cmd  = r_cmd;
        n_idx  = r_idx;
        n_busy = r_busy;
        o_pop  = 1'b0;
        if (!r_busy || (xfer && last)) begin
            if (!i_empty) begin
                n_cmd  = i_head;
                n_idx  = '0;
                n_busy = 1'b1;
                o_pop  = 1'b1;
            end else begin
                n_busy = 1'b0;
            end
        end else if (xfer) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_cmd.count))
        else $error("byte index beyond command length");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !last |=> r_busy && (r_idx == $past(r_idx) + 1'b1))
        else $error("run cut short");

endmodule

// ===== rtl/core/wildcard_to_regex_translator_top.sv =====
// path: an accepted item's command is written into the queue register; with the back end idle it
// is then popped into the serializer register, which drives the first output byte of the item
// throughput: one output byte per cycle while i_ready is high; an item yields 0 to 6 bytes
// the output byte rate is set by the back serializer; a small command queue lets input run ahead
// reset: synchronous active low, clears mode, ignore_case, escape flag, queue and serializer
module wildcard_to_regex_translator_top #(
    parameter int QUEUE_DEPTH = wtr_pkg::QUEUE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_opcode,
    input  logic [wtr_pkg::CHAR_W-1:0]           i_char_code,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [wtr_pkg::CHAR_W-1:0]           o_out_char,
    output logic                                 o_run_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wtr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wtr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    wtr_pkg::t_cmd cmd;
    wtr_pkg::t_cmd head;

    wtr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    wtr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    wtr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_run_last (o_run_last)
    );

endmodule
